/* sv/lss_pkg.sv */
// Shared types and constants for the LIFO stack with search.
`timescale 1ns / 1ps
`default_nettype none

package lss_pkg;

    localparam int DEPTH   = 128;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int CAP_W   = 8;
    localparam int UW      = (CW > CAP_W) ? CW : CAP_W;
    localparam int WORD_W  = 32;
    localparam int IDX_W   = 7;
    localparam int CNT_W   = 8;

    typedef logic [AW-1:0]     t_addr;
    typedef logic [CW-1:0]     t_cnt;
    typedef logic [UW-1:0]     t_capw;
    typedef logic [CAP_W-1:0]  t_cap;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]  t_index;
    typedef logic [CNT_W-1:0]  t_count;

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_PEEK   = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_SEARCH = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_NOTFOUND  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    ld_in;
        logic    res_clr;
        logic    st_we;
        t_status st;
        logic    push;
        logic    pop_dec;
        logic    clear_top;
        logic    rd_top;
        logic    scan_start;
        logic    scan_step;
        logic    ld_data;
        logic    ld_hit;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic top_zero;
        logic full;
        logic match;
        logic idx_zero;
    } t_dp_stat;

endpackage

`default_nettype wire

/* sv/lifo_stack_with_search_core.sv */
// Top level of the LIFO stack with search: controller plus datapath.
//
//  channel   direction  handshake              payload
//  request   in         i_valid / o_stall      i_cmd, i_value
//  result    out        o_valid / i_stall      o_status, o_data_out, o_found_index,
//                                              o_count, o_is_empty, o_is_full
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_data (capacity)
//
//  One request at a time. Push, clear and unknown commands go from accept through
//  EXEC to DONE; pop and peek of a non-empty stack add READ (one registered read).
//  Search of a non-empty stack scans in SCAN, one entry per cycle from the top
//  through the single memory read port, before DONE.
//  Synchronous active-low reset empties the stack and sets capacity to 128.
//  A stalled result holds; o_stall is high from accept until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module lifo_stack_with_search_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_cmd,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_data_out,
    output logic [6:0]              o_found_index,
    output logic [7:0]              o_count,
    output logic                    o_is_empty,
    output logic                    o_is_full,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [7:0]         i_cfg_data
);

    lss_pkg::t_dp_cmd  dp_cmd;
    lss_pkg::t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    lss_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .i_dp_stat (dp_stat),
        .o_dp_cmd  (dp_cmd)
    );

    lss_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid & o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .i_dp_cmd      (dp_cmd),
        .o_dp_stat     (dp_stat),
        .o_status      (o_status),
        .o_data_out    (o_data_out),
        .o_found_index (o_found_index),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

endmodule

`default_nettype wire

/* sv/lss_dp.sv */
// Datapath of the LIFO stack: storage, top pointer, capacity and result registers.
`timescale 1ns / 1ps
`default_nettype none

module lss_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire lss_pkg::t_cap        i_cfg_data,
    input  wire logic [2:0]           i_cmd,
    input  wire logic signed [31:0]   i_value,
    input  wire lss_pkg::t_dp_cmd     i_dp_cmd,
    output lss_pkg::t_dp_stat         o_dp_stat,
    output logic [1:0]                o_status,
    output logic signed [31:0]        o_data_out,
    output logic [6:0]                o_found_index,
    output logic [7:0]                o_count,
    output logic                      o_is_empty,
    output logic                      o_is_full
);

    lss_pkg::t_word   r_mem [lss_pkg::DEPTH];
    lss_pkg::t_word   r_rdata;
    lss_pkg::t_cnt    r_top;
    lss_pkg::t_cap    r_cap;
    logic [2:0]       r_cmd;
    lss_pkg::t_word   r_val;
    lss_pkg::t_addr   r_idx;
    lss_pkg::t_status r_status;
    lss_pkg::t_word   r_data;
    lss_pkg::t_addr   r_index;

    lss_pkg::t_capw   cap_use;
    lss_pkg::t_capw   top_ext;
    lss_pkg::t_addr   rd_addr;
    logic             rd_en;

    always_comb begin
        if (lss_pkg::t_capw'(r_cap) < lss_pkg::t_capw'(lss_pkg::DEPTH)) begin
            cap_use = lss_pkg::t_capw'(r_cap);
        end else begin
            cap_use = lss_pkg::t_capw'(lss_pkg::DEPTH);
        end
        top_ext = lss_pkg::t_capw'(r_top);
        if (i_dp_cmd.scan_step) begin
            rd_addr = r_idx - 1'b1;
        end else begin
            rd_addr = lss_pkg::t_addr'(r_top - 1'b1);
        end
        rd_en = i_dp_cmd.rd_top | i_dp_cmd.scan_start | i_dp_cmd.scan_step;
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.push) begin
            r_mem[lss_pkg::t_addr'(r_top)] <= r_val;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
            r_cap <= 8'd128;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_dp_cmd.clear_top) begin
                r_top <= '0;
            end else if (i_dp_cmd.push) begin
                r_top <= r_top + 1'b1;
            end else if (i_dp_cmd.pop_dec) begin
                r_top <= r_top - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.ld_in) begin
            r_cmd <= i_cmd;
            r_val <= i_value;
        end
        if (i_dp_cmd.scan_start) begin
            r_idx <= lss_pkg::t_addr'(r_top - 1'b1);
        end else if (i_dp_cmd.scan_step) begin
            r_idx <= r_idx - 1'b1;
        end
        if (i_dp_cmd.res_clr) begin
            r_status <= i_dp_cmd.st;
            r_data   <= '0;
            r_index  <= '0;
        end else begin
            if (i_dp_cmd.st_we) begin
                r_status <= i_dp_cmd.st;
            end
            if (i_dp_cmd.ld_data) begin
                r_data <= r_rdata;
            end
            if (i_dp_cmd.ld_hit) begin
                r_index <= r_idx;
            end
        end
    end

    assign o_dp_stat.cmd      = lss_pkg::t_cmd'(r_cmd);
    assign o_dp_stat.top_zero = (r_top == '0);
    assign o_dp_stat.full     = (top_ext >= cap_use);
    assign o_dp_stat.match    = (r_rdata == r_val);
    assign o_dp_stat.idx_zero = (r_idx == '0);

    assign o_status      = r_status;
    assign o_data_out    = r_data;
    assign o_found_index = lss_pkg::t_index'(r_index);
    assign o_count       = lss_pkg::t_count'(r_top);
    assign o_is_empty    = (r_top == '0);
    assign o_is_full     = (top_ext >= cap_use);

endmodule

`default_nettype wire

/* sv/lss_ctrl.sv */
// Controller state machine of the LIFO stack: sequences each request.
`timescale 1ns / 1ps
`default_nettype none

module lss_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    output logic                   o_valid,
    input  wire logic              i_stall,
    input  wire lss_pkg::t_dp_stat i_dp_stat,
    output lss_pkg::t_dp_cmd       o_dp_cmd
);

    lss_pkg::t_state r_state;
    lss_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        o_dp_cmd.st = lss_pkg::ST_OK;
        o_stall  = 1'b1;
        o_valid  = 1'b0;
        case (r_state)
            lss_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_dp_cmd.ld_in = 1'b1;
                    n_state = lss_pkg::S_EXEC;
                end
            end
            lss_pkg::S_EXEC: begin
                o_dp_cmd.res_clr = 1'b1;
                n_state = lss_pkg::S_DONE;
                case (i_dp_stat.cmd)
                    lss_pkg::CMD_PUSH: begin
                        if (i_dp_stat.full) begin
                            o_dp_cmd.st = lss_pkg::ST_OVERFLOW;
                        end else begin
                            o_dp_cmd.push = 1'b1;
                        end
                    end
                    lss_pkg::CMD_POP: begin
                        if (i_dp_stat.top_zero) begin
                            o_dp_cmd.st = lss_pkg::ST_UNDERFLOW;
                        end else begin
                            o_dp_cmd.rd_top  = 1'b1;
                            o_dp_cmd.pop_dec = 1'b1;
                            n_state = lss_pkg::S_READ;
                        end
                    end
                    lss_pkg::CMD_PEEK: begin
                        if (i_dp_stat.top_zero) begin
                            o_dp_cmd.st = lss_pkg::ST_UNDERFLOW;
                        end else begin
                            o_dp_cmd.rd_top = 1'b1;
                            n_state = lss_pkg::S_READ;
                        end
                    end
                    lss_pkg::CMD_CLEAR: begin
                        o_dp_cmd.clear_top = 1'b1;
                    end
                    lss_pkg::CMD_SEARCH: begin
                        if (i_dp_stat.top_zero) begin
                            o_dp_cmd.st = lss_pkg::ST_NOTFOUND;
                        end else begin
                            o_dp_cmd.scan_start = 1'b1;
                            n_state = lss_pkg::S_SCAN;
                        end
                    end
                    default: begin
                        o_dp_cmd.st = lss_pkg::ST_OK;
                    end
                endcase
            end
            lss_pkg::S_READ: begin
                o_dp_cmd.ld_data = 1'b1;
                n_state = lss_pkg::S_DONE;
            end
            lss_pkg::S_SCAN: begin
                if (i_dp_stat.match) begin
                    o_dp_cmd.ld_hit = 1'b1;
                    n_state = lss_pkg::S_DONE;
                end else if (i_dp_stat.idx_zero) begin
                    o_dp_cmd.st_we = 1'b1;
                    o_dp_cmd.st    = lss_pkg::ST_NOTFOUND;
                    n_state = lss_pkg::S_DONE;
                end else begin
                    o_dp_cmd.scan_step = 1'b1;
                end
            end
            lss_pkg::S_DONE: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_state = lss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lss_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
